// ----- rtl/lss_pkg.sv -----
// ---------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the Laplacian sharpening stream block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lss_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // tuser bit positions on the result side
  localparam int USER_ROW_END   = 0;
  localparam int USER_FRAME_END = 1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd240;

  // one accepted pixel, waiting for its line store reads
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] left;
    logic             has_out;
    logic             interior;
    logic             row_done;
    logic             last_row;
  } s1_t;

endpackage

// ----- rtl/laplacian_sharpen_stream_top.sv -----
// ---------------------------------------------------------------------------
// laplacian_sharpen_stream_top
// 3x3 Laplacian sharpening of a raster grey stream using two line stores.
// ---------------------------------------------------------------------------
// Takes one pixel per clock unless the output stalls. The pixel of row r,
// column c releases the result for row r-1, column c; on the last row each
// pixel also releases a zero border result, so there the output port, one
// result per cycle, lets in one pixel per two results. Each line store does
// one read and one write per pixel, which sets the one-pixel-per-clock rate.
// Line stores are not cleared; no clearing pass is needed after reset.
`timescale 1ns / 1ps

module laplacian_sharpen_stream_top
  import lss_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIX_W-1:0]      m_tdata,   // [7:0] pixel_out
  output logic                  m_tlast,   // run_last
  output logic [OUT_USER_W-1:0] m_tuser,   // [0] row_end, [1] frame_end
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > FW_W) ? WW : FW_W;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;

  logic [CW-1:0]    col;
  logic [FH_W-1:0]  row;

  logic [PIX_W-1:0] recent_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] recent_rd;
  logic [PIX_W-1:0] older_rd;
  logic [CW-1:0]    rd_addr;

  s1_t              s1;
  s1_t              s1_next;
  logic             s1_valid;
  logic             s1_go;
  logic             s1_silent;

  logic             o_valid;
  logic             o_pend;
  logic             o_pend_re;
  logic [PIX_W-1:0] o_pix;
  logic             o_re;
  logic             o_fe;
  logic             o_last;
  logic             out_free;

  logic             in_acc;
  logic [EW-1:0]    fw_ext;
  logic [EW-1:0]    w_eff;
  logic [FH_W-1:0]  h_eff;
  logic             row_done;
  logic             last_row;

  logic [9:0]       nb_sum;
  logic [10:0]      five_c;
  logic signed [11:0] diff;
  logic [PIX_W-1:0] sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = EW'(frame_width);
    if (fw_ext < EW'(3))
      w_eff = EW'(3);
    else if (fw_ext > EW'(MAX_WIDTH))
      w_eff = EW'(MAX_WIDTH);
    else
      w_eff = fw_ext;
    h_eff    = (frame_height < FH_W'(3)) ? FH_W'(3) : frame_height;
    row_done = EW'(col) >= (w_eff - EW'(1));
    last_row = row >= (h_eff - FH_W'(1));
    rd_addr  = row_done ? '0 : col + CW'(1);
  end

  // handshake
  assign s1_silent = !s1.has_out && !s1.last_row;
  assign out_free  = !o_valid || (m_tready && !o_pend);
  assign s1_go     = s1_valid && (out_free || s1_silent);
  assign s_tready  = !s1_valid || s1_go;
  assign in_acc    = s_tvalid && s_tready;

  // position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (row_done) begin
        col <= '0;
        row <= last_row ? '0 : row + FH_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // line stores: recent_rd is the look-ahead of the row above, which is the
  // next pixel's centre
  always_ff @(posedge clk) begin
    if (in_acc) begin
      recent_rd       <= recent_mem[rd_addr];
      older_rd        <= older_mem[col];
      recent_mem[col] <= s_tdata;
      older_mem[col]  <= recent_rd;
    end
  end

  always_comb begin
    s1_next          = s1;
    s1_next.pix      = s_tdata;
    s1_next.center   = recent_rd;
    s1_next.left     = s1.center;
    s1_next.has_out  = row != '0;
    s1_next.interior = (row > FH_W'(1)) && (row < h_eff) && (col != '0) && !row_done;
    s1_next.row_done = row_done;
    s1_next.last_row = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (in_acc) begin
      s1 <= s1_next;
    end
  end

  // kernel: 5*centre - left - right - up - down, saturated
  always_comb begin
    nb_sum = 10'(s1.left) + 10'(recent_rd) + 10'(older_rd) + 10'(s1.pix);
    five_c = {1'b0, s1.center, 2'b00} + 11'(s1.center);
    diff   = $signed({1'b0, five_c}) - $signed({2'b00, nb_sum});
    if (diff < 0)
      sat = '0;
    else if (diff > 12'sd255)
      sat = '1;
    else
      sat = diff[PIX_W-1:0];
  end

  // output register, one or two results per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      o_pend  <= 1'b0;
    end else if (o_valid && m_tready && o_pend) begin
      o_pend <= 1'b0;
    end else if (s1_go && !s1_silent) begin
      o_valid <= 1'b1;
      o_pend  <= s1.has_out && s1.last_row;
    end else if (o_valid && m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_valid && m_tready && o_pend) begin
      o_pix  <= '0;
      o_re   <= o_pend_re;
      o_fe   <= o_pend_re;
      o_last <= 1'b1;
    end else if (s1_go && !s1_silent) begin
      o_pend_re <= s1.row_done;
      o_re      <= s1.row_done;
      if (s1.has_out) begin
        o_pix  <= s1.interior ? sat : '0;
        o_fe   <= 1'b0;
        o_last <= !s1.last_row;
      end else begin
        o_pix  <= '0;
        o_fe   <= s1.row_done;
        o_last <= 1'b1;
      end
    end
  end

  assign m_tvalid                = o_valid;
  assign m_tdata                 = o_pix;
  assign m_tlast                 = o_last;
  assign m_tuser[USER_ROW_END]   = o_re;
  assign m_tuser[USER_FRAME_END] = o_fe;

endmodule

// ----- rtl/lss_checker.sv -----
// ---------------------------------------------------------------------------
// lss_checker
// Port-level checks of the Laplacian sharpening stream block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lss_checker
  import lss_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [PIX_W-1:0]      m_tdata,
  input logic                  m_tlast,
  input logic [OUT_USER_W-1:0] m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_fe_re: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_FRAME_END] |-> m_tuser[USER_ROW_END])
    else $error("frame end without row end");

  a_fe_border: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_FRAME_END] |-> m_tdata == '0 && m_tlast)
    else $error("frame end item not a closing border zero");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind laplacian_sharpen_stream_top lss_checker u_lss_checker (.*);

// ----- dv/tb_laplacian_sharpen_stream_top.sv -----
// ---------------------------------------------------------------------------
// tb_laplacian_sharpen_stream_top
// Self-checking bench for the 3x3 Laplacian sharpening stream.
// A local line-store predictor follows every accepted pixel and queues the
// results it releases; results are checked in order, field by field. The
// reset width comes first, then a short table of directed frames, the height
// and width extremes with mid-frame register writes, and random small frames.
// Random gaps are used on both sides, plus one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_laplacian_sharpen_stream_top;
  import lss_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int RAND_ITEMS = 280;
  localparam int SETTLE_CYC = 8;
  localparam int HOLD_CYC   = 300;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
    logic             run_last;
  } sharp_px_t;

  typedef enum logic [1:0] {OP_WIDTH, OP_HEIGHT, OP_PIXEL} dir_op_t;

  typedef struct packed {
    dir_op_t     op;
    logic [15:0] val;
    int          want;   // first result pixel, -1 when left to the predictor
  } dir_step_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [PIX_W-1:0] older_line  [MAX_W];
  logic [PIX_W-1:0] recent_line [MAX_W];
  logic [PIX_W-1:0] win_left;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  sharp_px_t sharp_q[$];
  int        err_cnt  = 0;
  int        idle_cyc = 0;
  bit        in_fast  = 1'b0;
  bit        out_fast = 1'b0;
  bit        hold_out = 1'b0;

  // width 0 / height 1 and width 2 / height 0 act as 3; two 3x3 frames hitting both saturation limits
  dir_step_t dir_steps [22] = '{
    '{OP_WIDTH,  16'd0, -1}, '{OP_HEIGHT, 16'd1, -1},
    '{OP_PIXEL,  16'd0, -1}, '{OP_PIXEL, 16'd0,   -1}, '{OP_PIXEL, 16'd0, -1},
    '{OP_PIXEL,  16'd0,  0}, '{OP_PIXEL, 16'd255,  0}, '{OP_PIXEL, 16'd0,  0},
    '{OP_PIXEL,  16'd0,  0}, '{OP_PIXEL, 16'd0,  255}, '{OP_PIXEL, 16'd0,  0},
    '{OP_WIDTH,  16'd2, -1}, '{OP_HEIGHT, 16'd0, -1},
    '{OP_PIXEL,  16'd255, -1}, '{OP_PIXEL, 16'd255, -1}, '{OP_PIXEL, 16'd255, -1},
    '{OP_PIXEL,  16'd255,  0}, '{OP_PIXEL, 16'd0,    0}, '{OP_PIXEL, 16'd255,  0},
    '{OP_PIXEL,  16'd255,  0}, '{OP_PIXEL, 16'd255,  0}, '{OP_PIXEL, 16'd255,  0}
  };

  laplacian_sharpen_stream_top #(
    .MAX_WIDTH (MAX_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] pixel_in
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [7:0] pixel_out
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),    // [0] row_end, [1] frame_end
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 3) ? 3 : 32'(height_reg);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel(input int mode);
    case (mode)
      0:       return 8'($urandom_range(0, 255));
      1:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    err_cnt++;
    $display("ERROR %0t ns: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // advance the line-store predictor by one accepted pixel
  task automatic sharpen_pixel(input logic [PIX_W-1:0] p, input int want);
    int unsigned w, h, c, r;
    logic        row_done, last_row;
    logic [7:0]  mid, right;
    int          acc;
    sharp_px_t   res;
    w = eff_width();
    h = eff_height();
    c = col_pos;
    r = row_pos;
    if (c >= MAX_W) c = MAX_W - 1;
    row_done = (c >= w - 1);
    last_row = (r >= h - 1);
    mid   = recent_line[c];
    right = (c + 1 < MAX_W) ? recent_line[c + 1] : 8'd0;
    if (r >= 1) begin
      res.pix = '0;
      if (r - 1 != 0 && r - 1 < h - 1 && c != 0 && !row_done) begin
        acc = 5 * int'(mid) - int'(win_left) - int'(right) - int'(older_line[c])
              - int'(p);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        res.pix = acc[7:0];
      end
      if (want >= 0) res.pix = want[7:0];
      res.row_end   = row_done;
      res.frame_end = 1'b0;
      res.run_last  = !last_row;
      sharp_q.push_back(res);
    end
    win_left       = mid;
    older_line[c]  = recent_line[c];
    recent_line[c] = p;
    if (last_row) begin
      res.pix       = '0;
      res.row_end   = row_done;
      res.frame_end = row_done;
      res.run_last  = 1'b1;
      sharp_q.push_back(res);
    end
    if (row_done) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      col_pos = (c + 1) & 32'h3FF;
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p, input int want);
    int n_gap;
    n_gap = in_fast ? 0 : int'($urandom_range(0, 3));
    if (n_gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (n_gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sharpen_pixel(p, want);
  endtask

  // send pixels until the current frame is complete
  task automatic finish_frame(input int mode);
    while (col_pos != 0 || row_pos != 0) send_pixel(rand_pixel(mode), -1);
  endtask

  // stop offering pixels and wait until the block has drained
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sharp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
    else height_reg = val;
  endtask

  // result side
  initial begin
    int        n_wait;
    sharp_px_t exp_px;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      n_wait = out_fast ? 0 : int'($urandom_range(0, 3));
      if (n_wait > 0) begin
        m_tready <= 1'b0;
        repeat (n_wait) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (sharp_q.size() == 0) begin
        flag_mismatch("unexpected result, pixel", -1, int'(m_tdata));
      end else begin
        exp_px = sharp_q.pop_front();
        if (m_tdata !== exp_px.pix)
          flag_mismatch("pixel_out", int'(exp_px.pix), int'(m_tdata));
        if (m_tuser[USER_ROW_END] !== exp_px.row_end)
          flag_mismatch("row_end", int'(exp_px.row_end), int'(m_tuser[USER_ROW_END]));
        if (m_tuser[USER_FRAME_END] !== exp_px.frame_end)
          flag_mismatch("frame_end", int'(exp_px.frame_end),
                        int'(m_tuser[USER_FRAME_END]));
        if (m_tlast !== exp_px.run_last)
          flag_mismatch("run_last", int'(exp_px.run_last), int'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    int i, k, mid_at, n_frame, pix_mode, rand_items;
    for (i = 0; i < MAX_W; i++) begin
      older_line[i]  = '0;
      recent_line[i] = '0;
    end
    win_left   = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    rand_items = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: one full row at width 320, the next pixel opens row 1;
    // then narrow and shorten the frame and close it
    for (i = 0; i < 321; i++) send_pixel(rand_pixel(0), -1);
    settle();
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    finish_frame(0);

    for (i = 0; i < 22; i++) begin
      if (dir_steps[i].op == OP_PIXEL) begin
        send_pixel(dir_steps[i].val[7:0], dir_steps[i].want);
      end else begin
        settle();
        write_reg(dir_steps[i].op == OP_WIDTH ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT,
                  dir_steps[i].val);
      end
    end

    // tallest frame, cut short mid-frame with rows already past the new end
    settle();
    write_reg(REG_FRAME_WIDTH, 16'd5);
    write_reg(REG_FRAME_HEIGHT, 16'd65535);
    for (i = 0; i < 25; i++) send_pixel(rand_pixel(2), -1);
    settle();
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    finish_frame(2);

    // widest setting, clamped to MAX_W, then narrowed mid-row; long output
    // stall on the last row, where results double
    settle();
    write_reg(REG_FRAME_WIDTH, 16'd2047);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    for (i = 0; i < 50; i++) send_pixel(rand_pixel(0), -1);
    settle();
    write_reg(REG_FRAME_WIDTH, 16'd8);
    for (i = 0; i < 9; i++) send_pixel(rand_pixel(0), -1);
    hold_out = 1'b1;
    finish_frame(1);

    while (rand_items < RAND_ITEMS) begin
      in_fast  = ($urandom_range(0, 3) == 0);
      out_fast = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        settle();
        case ($urandom_range(0, 9))
          0:       write_reg(REG_FRAME_WIDTH, 16'($urandom_range(0, 2)));
          1:       write_reg(REG_FRAME_WIDTH, 16'($urandom_range(13, 40)));
          default: write_reg(REG_FRAME_WIDTH, 16'($urandom_range(3, 12)));
        endcase
        write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                                               : 16'($urandom_range(3, 7)));
      end
      pix_mode = int'($urandom_range(0, 2));
      n_frame  = int'(eff_width() * eff_height());
      mid_at   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, n_frame - 2)) : -1;
      k = 0;
      do begin
        if (k == mid_at) begin
          // mid-frame: width may only shrink, the stores beyond are unwritten
          settle();
          if ($urandom_range(0, 1))
            write_reg(REG_FRAME_WIDTH, 16'($urandom_range(0, eff_width())));
          else
            write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(0, 10)));
        end
        send_pixel(rand_pixel(pix_mode), -1);
        k++;
        rand_items++;
      end while (col_pos != 0 || row_pos != 0);
    end

    s_tvalid <= 1'b0;
    while (sharp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && sharp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lss_pkg.sv
rtl/laplacian_sharpen_stream_top.sv
rtl/lss_checker.sv
dv/tb_laplacian_sharpen_stream_top.sv
